[rtl/core/spbar_pkg.sv]
// Shared types and constants for the spectrum bar column renderer.
package spbar_pkg;

   localparam int BANDS      = 64;
   localparam int ROWS       = 40;
   localparam int BAND_W     = 6;
   localparam int MAG_W      = 16;
   localparam int COL_W      = 7;
   localparam int MASK_W     = 40;
   localparam int PEAK_W     = 14;
   localparam int HEIGHT_W   = 7;
   localparam int PROD_W     = MAG_W + HEIGHT_W;
   localparam int GAIN       = 120;
   localparam int PEAK_FALL  = 102;
   localparam int PEAK_MAX   = 16383;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the CSR port (byte address = 4 * index).
   localparam logic [0:0] REG_DRAW_MODE  = 1'b0;
   localparam logic [0:0] REG_SHOW_PEAKS = 1'b1;

   // Drawing modes.
   localparam logic [1:0] MODE_BARS   = 2'd0;
   localparam logic [1:0] MODE_MIRROR = 2'd1;
   localparam logic [1:0] MODE_DOTS   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic [BAND_W-1:0] band_index;
      logic [MAG_W-1:0]  magnitude;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [MASK_W-1:0] column_mask;
   } rsp_type;

endpackage

[rtl/core/spectrum_bar_column_renderer_core.sv]
// Spectrum bar column renderer: bar height, peak hold store and column mask build.
// Requests pass the input stage, then the result register; one request per cycle is
// taken unless rsp_stall backs up the pipe. The peak store is a 64-entry RAM with one read
// and one write port, and a write-to-read bypass covers back-to-back same-band requests.
// Reset (synchronous, active high) clears both stages, the CSRs and the peak valid bits,
// so every band's peak reads as zero right after reset with no clearing pass.
module spectrum_bar_column_renderer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  spbar_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spbar_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [spbar_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [spbar_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [spbar_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [1:0] draw_mode_ff;
   logic       show_peaks_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff  <= spbar_pkg::MODE_BARS;
         show_peaks_ff <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            spbar_pkg::REG_DRAW_MODE:  draw_mode_ff  <= pwdata[1:0];
            spbar_pkg::REG_SHOW_PEAKS: show_peaks_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         spbar_pkg::REG_DRAW_MODE:
            prdata = {{(spbar_pkg::CSR_DATA_W-2){1'b0}}, draw_mode_ff};
         spbar_pkg::REG_SHOW_PEAKS:
            prdata = {{(spbar_pkg::CSR_DATA_W-1){1'b0}}, show_peaks_ff};
         default:
            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Handshake: the result register frees up when empty or taken,
   // and the input stage loads whenever it is empty or moves on.
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic rsp_load;
   logic req_accept;

   assign rsp_load   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = s1_valid_ff & ~rsp_load;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;

   // Input stage payload
   spbar_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // Peak store: RAM with registered read at request accept, one
   // valid bit per band so unwritten bands read as zero after reset.
   // ---------------------------------------------------------------
   logic [spbar_pkg::PEAK_W-1:0] peak_mem_ff [spbar_pkg::BANDS];
   logic [spbar_pkg::PEAK_W-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic [spbar_pkg::BANDS-1:0]  peak_vld_ff;
   logic [spbar_pkg::PEAK_W-1:0] fwd_data_ff;
   logic                         fwd_hit_ff;
   logic                         peak_we;
   logic [spbar_pkg::PEAK_W-1:0] peak_new;
   logic                         band_in_range;

   // Band index is 6 bits; compare against BANDS in a wider space.
   assign band_in_range = ({1'b0, s1_req_ff.band_index} < 7'(spbar_pkg::BANDS));
   // With peaks shown, write the updated peak once, as the item leaves the input stage.
   assign peak_we = s1_valid_ff & rsp_load & show_peaks_ff & band_in_range;

   always_ff @(posedge clock) begin
      if (peak_we) begin
         peak_mem_ff[s1_req_ff.band_index] <= peak_new;
      end
      if (req_accept) begin
         rd_data_ff <= peak_mem_ff[req_data.band_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_vld_ff <= '0;
      end else if (peak_we) begin
         peak_vld_ff[s1_req_ff.band_index] <= 1'b1;
      end
   end

   // Bypass: a request accepted on the same edge as a write to its band
   // would read the stale entry, so capture the written value instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else if (req_accept) begin
         fwd_hit_ff <= peak_we & (req_data.band_index == s1_req_ff.band_index);
         rd_vld_ff  <= peak_vld_ff[req_data.band_index];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_data_ff <= peak_new;
      end
   end

   // ---------------------------------------------------------------
   // Bar height, peak update and mask build
   // ---------------------------------------------------------------
   logic [spbar_pkg::PROD_W-1:0]   product;
   logic [spbar_pkg::HEIGHT_W-1:0] height_raw;
   logic [spbar_pkg::HEIGHT_W-1:0] height;
   logic [spbar_pkg::PEAK_W-1:0]   peak_old;
   logic [spbar_pkg::PEAK_W:0]     height_q;
   logic [spbar_pkg::PEAK_W:0]     peak_sel;
   logic [spbar_pkg::PEAK_W-1:0]   peak_cur;
   logic [5:0]                     peak_int;
   logic [5:0]                     peak_row;
   logic [5:0]                     top_row;
   logic [spbar_pkg::MASK_W-1:0]   bar_mask;
   logic [spbar_pkg::MASK_W-1:0]   dot_mask;
   logic [spbar_pkg::MASK_W-1:0]   peak_mask;
   logic [spbar_pkg::MASK_W-1:0]   mask;
   logic [5:0]                     half_band;
   logic [5:0]                     col_x;
   spbar_pkg::rsp_type             rsp_in;
   spbar_pkg::rsp_type             rsp_ff;

   always_comb begin
      product    = spbar_pkg::PROD_W'(s1_req_ff.magnitude) * spbar_pkg::PROD_W'(spbar_pkg::GAIN);
      height_raw = product[spbar_pkg::PROD_W-1:spbar_pkg::MAG_W];
      // Clamp the bar to the display height.
      height     = (height_raw > spbar_pkg::HEIGHT_W'(spbar_pkg::ROWS))
                   ? spbar_pkg::HEIGHT_W'(spbar_pkg::ROWS) : height_raw;

      peak_old = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : '0);
      height_q = {height, 8'd0};

      // Rise to a higher bar, else decay toward zero.
      if (height_q > {1'b0, peak_old}) begin
         peak_sel = height_q;
      end else if (peak_old > spbar_pkg::PEAK_W'(spbar_pkg::PEAK_FALL)) begin
         peak_sel = {1'b0, peak_old - spbar_pkg::PEAK_W'(spbar_pkg::PEAK_FALL)};
      end else begin
         peak_sel = '0;
      end
      peak_new = (peak_sel > (spbar_pkg::PEAK_W+1)'(spbar_pkg::PEAK_MAX))
                 ? spbar_pkg::PEAK_W'(spbar_pkg::PEAK_MAX) : peak_sel[spbar_pkg::PEAK_W-1:0];

      peak_cur = show_peaks_ff ? peak_new : peak_old;
      peak_int = peak_cur[spbar_pkg::PEAK_W-1:8];
      peak_row = (peak_int >= 6'(spbar_pkg::ROWS - 1)) ? 6'd0
                 : 6'(spbar_pkg::ROWS - 1) - peak_int;

      // Bar fills the bottom rows: top "height" bits of the mask.
      bar_mask  = ~({spbar_pkg::MASK_W{1'b1}} >> height);
      top_row   = 6'(spbar_pkg::ROWS) - height[5:0];
      dot_mask  = (height != '0) ? (spbar_pkg::MASK_W'(1) << top_row) : '0;
      peak_mask = spbar_pkg::MASK_W'(1) << peak_row;

      half_band = {1'b0, s1_req_ff.band_index[5:1]};
      col_x     = s1_req_ff.band_index;
      mask      = '0;
      if (band_in_range) begin
         case (draw_mode_ff)
            spbar_pkg::MODE_BARS, spbar_pkg::MODE_MIRROR: begin
               if (draw_mode_ff == spbar_pkg::MODE_MIRROR) begin
                  // Even bands grow right of center, odd bands left of it.
                  col_x = s1_req_ff.band_index[0]
                          ? 6'(spbar_pkg::BANDS / 2) - half_band - 6'd1
                          : 6'(spbar_pkg::BANDS / 2) + half_band;
               end
               mask = bar_mask | (show_peaks_ff ? peak_mask : '0);
            end
            spbar_pkg::MODE_DOTS: mask = dot_mask;
            spbar_pkg::MODE_NONE: mask = '0;
            default:              mask = '0;
         endcase
      end

      rsp_in.column      = {col_x, 1'b0};
      rsp_in.column_mask = mask;
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load & s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
